### sv/msd_pkg.sv
package msd_pkg;

    localparam int CHANNELS_DEFAULT = 16;

    localparam int CHANNEL_W    = 4;
    localparam int NUM_CH_CODES = 2 ** CHANNEL_W;
    localparam int TIME_W       = 32;
    localparam int INTERVAL_W   = 16;
    localparam int MODE_W       = 2;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = INTERVAL_W;

    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 1'd1;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd10;

    localparam logic [MODE_W-1:0] MODE_STABLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOCKOUT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PROMPT  = 2'd2;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_ATTACH = 1'b1;

    typedef struct packed {
        logic                 func;
        logic [CHANNEL_W-1:0] channel;
        logic                 level;
        logic [TIME_W-1:0]    now_ms;
    } item_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel_out;
        logic                 debounced;
        logic                 changed;
        logic                 rose;
        logic                 fell;
    } result_t;

endpackage

### sv/msd_stream_if.sv
interface msd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

### sv/multi_channel_switch_debouncer_unit.sv
// Debouncer for up to 16 switch channels sharing one interval register. Each item
// names a channel, its raw level and the current millisecond time stamp, and either
// samples the channel (stable-wait, lock-out or prompt detection, set by the mode
// register) or attaches it. Every item gives exactly one result with the debounced
// level and the changed, rose and fell flags; a channel at or above CHANNELS leaves
// all state alone and reports a zero level and flags. Items are registered in the
// input stage, then in the result register; the per-channel state update is a single
// 32-bit subtract and compare, so one item is accepted every cycle while results are
// taken. A waiting result holds the item behind it; both registers full stops input.
// The user must write configuration only while idle; the block does not enforce it.
module multi_channel_switch_debouncer_unit
    import msd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    msd_stream_if.sink             items,
    msd_stream_if.source           results
);

    localparam int DEPTH = (CHANNELS < NUM_CH_CODES) ? CHANNELS : NUM_CH_CODES;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [INTERVAL_W-1:0] interval_reg;
    logic [MODE_W-1:0]     mode_reg;

    logic                  stage_valid_reg;
    item_t                 stage_reg;
    logic                  res_valid_reg;
    result_t               res_reg;

    logic [DEPTH-1:0]      deb_reg;
    logic [DEPTH-1:0]      unst_reg;
    logic [TIME_W-1:0]     last_reg [DEPTH];

    logic                  advance;
    logic                  in_range;
    logic [IDX_W-1:0]      idx;
    logic                  cur_deb;
    logic                  cur_unst;
    logic [TIME_W-1:0]     cur_last;
    logic                  elapsed;
    logic                  deb_next;
    logic                  unst_next;
    logic [TIME_W-1:0]     last_next;
    logic                  chg;
    result_t               res_next;

    assign advance       = stage_valid_reg && (!res_valid_reg || results.ready);
    assign items.ready   = !stage_valid_reg || advance;
    assign results.valid = res_valid_reg;
    assign results.payload = res_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
            mode_reg     <= MODE_STABLE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INTERVAL: interval_reg <= cfg_data[INTERVAL_W-1:0];
                REG_MODE:     mode_reg     <= cfg_data[MODE_W-1:0];
                default:      ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (items.ready)
        begin
            stage_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            stage_reg <= items.payload;
        end
    end

    assign idx      = stage_reg.channel[IDX_W-1:0];
    assign in_range = int'(stage_reg.channel) < CHANNELS;
    assign cur_deb  = deb_reg[idx];
    assign cur_unst = unst_reg[idx];
    assign cur_last = last_reg[idx];
    assign elapsed  = (stage_reg.now_ms - cur_last) >= TIME_W'(interval_reg);

    always_comb
    begin
        deb_next  = cur_deb;
        unst_next = cur_unst;
        last_next = cur_last;
        chg       = 1'b0;
        if (stage_reg.func == FUNC_ATTACH)
        begin
            deb_next  = stage_reg.level;
            unst_next = stage_reg.level;
            last_next = (mode_reg == MODE_LOCKOUT) ? '0 : stage_reg.now_ms;
        end
        else
        begin
            case (mode_reg)
                MODE_LOCKOUT:
                begin
                    if (elapsed && (cur_deb != stage_reg.level))
                    begin
                        last_next = stage_reg.now_ms;
                        deb_next  = stage_reg.level;
                        chg       = 1'b1;
                    end
                end
                MODE_PROMPT:
                begin
                    if ((stage_reg.level != cur_deb) && elapsed)
                    begin
                        deb_next = stage_reg.level;
                        chg      = 1'b1;
                    end
                    if (stage_reg.level != cur_unst)
                    begin
                        unst_next = stage_reg.level;
                        last_next = stage_reg.now_ms;
                    end
                end
                default:
                begin
                    if (stage_reg.level != cur_unst)
                    begin
                        last_next = stage_reg.now_ms;
                        unst_next = stage_reg.level;
                    end
                    else if (elapsed && (cur_deb != stage_reg.level))
                    begin
                        last_next = stage_reg.now_ms;
                        deb_next  = stage_reg.level;
                        chg       = 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        res_next.channel_out = stage_reg.channel;
        res_next.debounced   = in_range && deb_next;
        res_next.changed     = in_range && chg;
        res_next.rose        = in_range && chg && deb_next;
        res_next.fell        = in_range && chg && !deb_next;
    end

    // per-channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg  <= '0;
            unst_reg <= '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                last_reg[i] <= '0;
            end
        end
        else if (advance && in_range)
        begin
            deb_reg[idx]  <= deb_next;
            unst_reg[idx] <= unst_next;
            last_reg[idx] <= last_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!res_valid_reg || results.ready)
        begin
            res_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

### tb/tb_top.sv
module tb_top;
    import msd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CHANNELS  = CHANNELS_DEFAULT;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;

    // mode code with no meaning of its own, handled as stable-wait
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    msd_stream_if #(.payload_t(item_t))   item_bus ();
    msd_stream_if #(.payload_t(result_t)) result_bus ();

    multi_channel_switch_debouncer_unit #(
        .CHANNELS (NUM_CHANNELS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (item_bus),
        .results   (result_bus)
    );

    // debouncer state as the block should hold it
    logic [INTERVAL_W-1:0] cur_interval;
    logic [MODE_W-1:0]     cur_mode;
    logic                  deb_level [NUM_CHANNELS];
    logic                  raw_level [NUM_CHANNELS];
    logic                  chg_flag  [NUM_CHANNELS];
    logic [TIME_W-1:0]     event_ms  [NUM_CHANNELS];

    result_t expected_results [$];

    int  mismatch_count;
    int  items_sent;
    int  results_checked;
    int  edges_seen;
    bit  gaps_on;
    bit  stalls_on;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("timeout with %0d results still pending", expected_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic bit interval_met(int unsigned ch, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        elapsed = now - event_ms[ch];
        return elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, cur_interval};
    endfunction

    function automatic result_t predict_debounce(item_t it);
        result_t     r;
        int unsigned ch;
        bit          ok;
        r = '0;
        r.channel_out = it.channel;
        ch = 32'(it.channel);
        if (ch >= NUM_CHANNELS)
            return r;
        if (it.func == FUNC_ATTACH)
        begin
            deb_level[ch] = it.level;
            raw_level[ch] = it.level;
            chg_flag[ch]  = 1'b0;
            event_ms[ch]  = (cur_mode == MODE_LOCKOUT) ? '0 : it.now_ms;
        end
        else
        begin
            ok = interval_met(ch, it.now_ms);
            chg_flag[ch] = 1'b0;
            case (cur_mode)
                MODE_LOCKOUT:
                begin
                    if (ok && deb_level[ch] != it.level)
                    begin
                        event_ms[ch]  = it.now_ms;
                        deb_level[ch] = it.level;
                        chg_flag[ch]  = 1'b1;
                    end
                end
                MODE_PROMPT:
                begin
                    if (it.level != deb_level[ch] && ok)
                    begin
                        deb_level[ch] = it.level;
                        chg_flag[ch]  = 1'b1;
                    end
                    if (it.level != raw_level[ch])
                    begin
                        raw_level[ch] = it.level;
                        event_ms[ch]  = it.now_ms;
                    end
                end
                default:
                begin
                    if (it.level != raw_level[ch])
                    begin
                        event_ms[ch]  = it.now_ms;
                        raw_level[ch] = it.level;
                    end
                    else if (ok && deb_level[ch] != it.level)
                    begin
                        event_ms[ch]  = it.now_ms;
                        deb_level[ch] = it.level;
                        chg_flag[ch]  = 1'b1;
                    end
                end
            endcase
        end
        r.debounced = deb_level[ch];
        r.changed   = chg_flag[ch];
        r.rose      = chg_flag[ch] & deb_level[ch];
        r.fell      = chg_flag[ch] & ~deb_level[ch];
        return r;
    endfunction

    // result side: random stall bursts
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = result_bus.payload;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: ch %0d deb %0b chg %0b rose %0b fell %0b",
                             got.channel_out, got.debounced, got.changed, got.rose, got.fell);
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (got.changed === 1'b1)
                    edges_seen++;
                if (got.channel_out !== want.channel_out || got.debounced !== want.debounced ||
                    got.changed !== want.changed || got.rose !== want.rose ||
                    got.fell !== want.fell)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected ch %0d deb %0b chg %0b rose %0b fell %0b, %s",
                                 want.channel_out, want.debounced, want.changed, want.rose,
                                 want.fell,
                                 $sformatf("got ch %0d deb %0b chg %0b rose %0b fell %0b",
                                           got.channel_out, got.debounced, got.changed,
                                           got.rose, got.fell));
                end
            end
        end
    end

    task automatic send_item(logic fn, logic [CHANNEL_W-1:0] ch, logic lv,
                             logic [TIME_W-1:0] now);
        item_t it;
        it.func    = fn;
        it.channel = ch;
        it.level   = lv;
        it.now_ms  = now;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.payload <= it;
        do
            @(posedge clk);
        while (!item_bus.ready);
        expected_results.push_back(predict_debounce(it));
        items_sent++;
    endtask

    task automatic drain_results();
        int waited;
        @(negedge clk);
        item_bus.valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_INTERVAL)
            cur_interval = val;
        else if (idx == REG_MODE)
            cur_mode = val[MODE_W-1:0];
    endtask

    // reset values: stable-wait with interval 10, plus time wrap
    task automatic test_stable_defaults();
        send_item(FUNC_ATTACH, 4'd0, 1'b1, 32'd100);
        send_item(FUNC_SAMPLE, 4'd0, 1'b0, 32'd101);
        send_item(FUNC_SAMPLE, 4'd0, 1'b0, 32'd110);
        send_item(FUNC_SAMPLE, 4'd0, 1'b0, 32'd111);
        send_item(FUNC_SAMPLE, 4'd15, 1'b1, 32'd0);
        send_item(FUNC_SAMPLE, 4'd15, 1'b1, 32'hFFFF_FFFF);
        send_item(FUNC_ATTACH, 4'd3, 1'b0, 32'hFFFF_FFFA);
        send_item(FUNC_SAMPLE, 4'd3, 1'b1, 32'hFFFF_FFFB);
        send_item(FUNC_SAMPLE, 4'd3, 1'b1, 32'd5);
    endtask

    // lock-out at the widest interval; attach clears the time stamp
    task automatic test_lockout();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_LOCKOUT));
        write_reg(REG_INTERVAL, 16'hFFFF);
        send_item(FUNC_ATTACH, 4'd7, 1'b0, 32'd50);
        send_item(FUNC_SAMPLE, 4'd7, 1'b1, 32'd3);
        send_item(FUNC_SAMPLE, 4'd7, 1'b1, 32'd65535);
        send_item(FUNC_SAMPLE, 4'd7, 1'b0, 32'd65536);
        send_item(FUNC_SAMPLE, 4'd7, 1'b0, 32'd131070);
    endtask

    task automatic test_prompt();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_PROMPT));
        write_reg(REG_INTERVAL, 16'd20);
        send_item(FUNC_ATTACH, 4'd9, 1'b0, 32'd1000);
        send_item(FUNC_SAMPLE, 4'd9, 1'b1, 32'd1030);
        send_item(FUNC_SAMPLE, 4'd9, 1'b0, 32'd1035);
        send_item(FUNC_SAMPLE, 4'd9, 1'b0, 32'd1055);
    endtask

    // all-ones write to the mode register lands on the unused code
    task automatic test_unused_mode();
        write_reg(REG_MODE, 16'hFFFF);
        write_reg(REG_INTERVAL, 16'd0);
        send_item(FUNC_SAMPLE, 4'd2, 1'b1, 32'd7);
        send_item(FUNC_SAMPLE, 4'd2, 1'b1, 32'd7);
        send_item(FUNC_SAMPLE, 4'd2, 1'b0, 32'h8000_0000);
        send_item(FUNC_SAMPLE, 4'd2, 1'b0, 32'h8000_0000);
        write_reg(REG_MODE, CFG_DATA_W'(MODE_UNUSED));
    endtask

    task automatic test_random_traffic();
        logic [TIME_W-1:0]    clock_ms;
        logic [CHANNEL_W-1:0] base_ch;
        logic [CHANNEL_W-1:0] ch;
        logic                 held [NUM_CHANNELS];
        logic                 lv;
        logic                 fn;
        logic [TIME_W-1:0]    now;
        int                   pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 3)));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_reg(REG_INTERVAL, 16'd0);
            else if (pick == 1)
                write_reg(REG_INTERVAL, 16'hFFFF);
            else if (pick < 4)
                write_reg(REG_INTERVAL, CFG_DATA_W'($urandom_range(1, 1000)));
            else
                write_reg(REG_INTERVAL, CFG_DATA_W'($urandom_range(1, 40)));
            if (phase >= RANDOM_PHASES - 2)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            else
            begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            clock_ms = $urandom;
            if ($urandom_range(0, 3) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
            base_ch = CHANNEL_W'($urandom_range(0, 15));
            for (int i = 0; i < NUM_CHANNELS; i++)
                held[i] = 1'($urandom_range(0, 1));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                    ch = CHANNEL_W'($urandom_range(0, 15));
                else
                    ch = base_ch + CHANNEL_W'($urandom_range(0, 2));
                clock_ms += $urandom_range(0, (cur_interval >> 2) + 2);
                if ($urandom_range(0, 7) == 0)
                    held[ch] = ~held[ch];
                lv  = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : held[ch];
                fn  = ($urandom_range(0, 19) == 0) ? FUNC_ATTACH : FUNC_SAMPLE;
                now = ($urandom_range(0, 24) == 0) ? $urandom : clock_ms;
                send_item(fn, ch, lv, now);
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        item_bus.valid   = 1'b0;
        item_bus.payload = '0;
        mismatch_count   = 0;
        items_sent       = 0;
        results_checked  = 0;
        edges_seen       = 0;
        gaps_on          = 1'b1;
        stalls_on        = 1'b1;
        cur_interval     = INTERVAL_RESET;
        cur_mode         = MODE_STABLE;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            deb_level[i] = 1'b0;
            raw_level[i] = 1'b0;
            chg_flag[i]  = 1'b0;
            event_ms[i]  = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_stable_defaults();
        test_lockout();
        test_prompt();
        test_unused_mode();
        test_random_traffic();

        drain_results();
        if (expected_results.size() != 0)
        begin
            mismatch_count++;
            $display("%0d expected results never arrived", expected_results.size());
        end
        $display("sent %0d items over all debounce modes and interval extremes", items_sent);
        $display("checked %0d results, %0d of them with a debounced edge",
                 results_checked, edges_seen);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
